### src/acpu_pkg.sv
// acpu_pkg: shared constants, operation codes and the execute result type
// for the accumulator cpu execute unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package acpu_pkg;

  // data path and address widths
  localparam int DATA_W    = 8;
  localparam int OPC_W     = 5;
  localparam int SEL_W     = 3;
  localparam int ADDR_W    = SEL_W + DATA_W;
  localparam int NUM_REGS  = 1 << SEL_W;

  // data memory size; addresses at or beyond it read zero and drop stores
  localparam int MEM_DEPTH = 2048;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // stream payload widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // operation codes, opcode byte bits 7..3
  localparam logic [OPC_W-1:0] OP_NOP = 5'h00;
  localparam logic [OPC_W-1:0] OP_NOT = 5'h01;
  localparam logic [OPC_W-1:0] OP_LDR = 5'h02;
  localparam logic [OPC_W-1:0] OP_STR = 5'h03;
  localparam logic [OPC_W-1:0] OP_ORR = 5'h04;
  localparam logic [OPC_W-1:0] OP_AND = 5'h05;
  localparam logic [OPC_W-1:0] OP_XOR = 5'h06;
  localparam logic [OPC_W-1:0] OP_ADD = 5'h07;
  localparam logic [OPC_W-1:0] OP_BSL = 5'h08;
  localparam logic [OPC_W-1:0] OP_BSR = 5'h09;
  localparam logic [OPC_W-1:0] OP_BRL = 5'h0A;
  localparam logic [OPC_W-1:0] OP_BRR = 5'h0B;
  localparam logic [OPC_W-1:0] OP_LDI = 5'h11;
  localparam logic [OPC_W-1:0] OP_LDM = 5'h12;
  localparam logic [OPC_W-1:0] OP_STM = 5'h13;
  localparam logic [OPC_W-1:0] OP_JMP = 5'h14;
  localparam logic [OPC_W-1:0] OP_JC0 = 5'h15;
  localparam logic [OPC_W-1:0] OP_JC1 = 5'h16;
  localparam logic [OPC_W-1:0] OP_JA0 = 5'h1D;
  localparam logic [OPC_W-1:0] OP_JA1 = 5'h1E;

  // outcome of one instruction from the execute logic
  typedef struct packed {
    logic [DATA_W-1:0] acc;
    logic              carry;
    logic              jump_taken;
    logic [ADDR_W-1:0] jump_target;
    logic              reg_we;
    logic              mem_we;
  } exe_res_t;

endpackage

`default_nettype wire

### src/acpu_ram.sv
// acpu_ram: generic single write port, single read port synchronous ram
// with a registered read; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module acpu_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/acpu_alu.sv
// acpu_alu: combinational execute logic of one instruction against the
// accumulator, carry, selected register and loaded memory byte; uses acpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module acpu_alu (
  input  wire logic [acpu_pkg::OPC_W-1:0]  op,
  input  wire logic [acpu_pkg::SEL_W-1:0]  sel,
  input  wire logic [acpu_pkg::DATA_W-1:0] arg,
  input  wire logic [acpu_pkg::DATA_W-1:0] acc,
  input  wire logic                        carry,
  input  wire logic [acpu_pkg::DATA_W-1:0] reg_data,
  input  wire logic [acpu_pkg::DATA_W-1:0] mem_data,
  input  wire logic                        mem_ok,
  output acpu_pkg::exe_res_t               res
);

  logic [acpu_pkg::DATA_W:0] sum;
  logic                      jump;

  assign sum = {1'b0, acc} + {1'b0, reg_data};

  // operation decode and result
  always_comb begin
    res        = '0;
    res.acc    = acc;
    res.carry  = carry;
    jump       = 1'b0;
    case (op)
      acpu_pkg::OP_NOT: res.acc = ~acc;
      acpu_pkg::OP_LDR: res.acc = reg_data;
      acpu_pkg::OP_STR: res.reg_we = 1'b1;
      acpu_pkg::OP_LDM: res.acc = mem_data;
      acpu_pkg::OP_STM: res.mem_we = mem_ok;
      acpu_pkg::OP_LDI: res.acc = arg;
      acpu_pkg::OP_ORR: res.acc = acc | reg_data;
      acpu_pkg::OP_AND: res.acc = acc & reg_data;
      acpu_pkg::OP_XOR: res.acc = acc ^ reg_data;
      acpu_pkg::OP_ADD: begin
        res.acc   = sum[acpu_pkg::DATA_W-1:0];
        res.carry = sum[acpu_pkg::DATA_W];
      end
      acpu_pkg::OP_BSL: res.acc = {acc[acpu_pkg::DATA_W-2:0], 1'b0};
      acpu_pkg::OP_BSR: res.acc = {1'b0, acc[acpu_pkg::DATA_W-1:1]};
      acpu_pkg::OP_BRL: res.acc = {acc[acpu_pkg::DATA_W-2:0], acc[acpu_pkg::DATA_W-1]};
      acpu_pkg::OP_BRR: res.acc = {acc[0], acc[acpu_pkg::DATA_W-1:1]};
      acpu_pkg::OP_JMP: jump = 1'b1;
      acpu_pkg::OP_JC0: jump = ~carry;
      acpu_pkg::OP_JC1: jump = carry;
      acpu_pkg::OP_JA0: jump = (acc == '0);
      acpu_pkg::OP_JA1: jump = (acc != '0);
      default: ;
    endcase
    res.jump_taken  = jump;
    res.jump_target = jump ? {sel, arg} : '0;
  end

endmodule

`default_nettype wire

### src/accumulator_cpu_execute_unit.sv
// accumulator_cpu_execute_unit: top level with the issue stage, data memory,
// register file, execute stage and output register; uses acpu_pkg, acpu_ram, acpu_alu
//
//   channel   direction  tdata fields (low bit up)
//   s_axis    in         opcode_byte[7:0], operand_byte[15:8]
//   m_axis    out        accumulator[7:0], carry_flag[8], jump_taken[9],
//                        jump_target[20:10], zero[23:21]
//
// One instruction per cycle unless m_axis stalls or clearing runs: an instruction
// is registered and its memory read issued in the issue stage, then executed and its
// result registered in the output register. A store in execute that hits the address
// read by the next instruction is forwarded. After reset the data memory is zeroed
// one byte a cycle, all MEM_DEPTH bytes, with s_axis_tready low. A stall on m_axis
// holds the output register while one more instruction is taken.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_cpu_execute_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // opcode_byte[7:0], operand_byte[15:8]
  input  wire logic [acpu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // accumulator[7:0], carry_flag[8], jump_taken[9], jump_target[20:10]
  output logic      [acpu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int DW = acpu_pkg::DATA_W;
  localparam int AW = acpu_pkg::ADDR_W;
  localparam int MW = acpu_pkg::MEM_AW;

  // clearing pass
  logic          clearing;
  logic [MW-1:0] clr_addr;

  // issue stage
  logic                       s1_valid;
  logic [acpu_pkg::OPC_W-1:0] s1_op;
  logic [acpu_pkg::SEL_W-1:0] s1_sel;
  logic [DW-1:0]              s1_arg;
  logic                       s1_mem_ok;
  logic                       s1_fwd;
  logic [DW-1:0]              s1_fwd_data;

  // architectural state
  logic [DW-1:0] acc_reg;
  logic          carry_reg;
  logic [DW-1:0] regs [acpu_pkg::NUM_REGS];

  // output register
  logic          out_valid;
  logic [DW-1:0] out_acc;
  logic          out_carry;
  logic          out_jump;
  logic [AW-1:0] out_target;

  logic               in_accept;
  logic               exe_fire;
  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      s1_addr;
  logic               in_mem_ok;
  logic [DW-1:0]      rdata;
  logic [DW-1:0]      mem_data;
  logic               ram_we;
  logic [MW-1:0]      ram_waddr;
  logic [DW-1:0]      ram_wdata;
  acpu_pkg::exe_res_t res;

  // handshakes
  assign exe_fire      = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || exe_fire);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // address decode
  assign in_addr   = {s_axis_tdata[acpu_pkg::SEL_W-1:0], s_axis_tdata[2*DW-1:DW]};
  assign s1_addr   = {s1_sel, s1_arg};
  assign in_mem_ok = ({1'b0, in_addr} < (AW+1)'(acpu_pkg::MEM_DEPTH));

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == MW'(acpu_pkg::MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // data memory write port: clearing pass or store
  assign ram_we    = clearing || (exe_fire && res.mem_we);
  assign ram_waddr = clearing ? clr_addr : s1_addr[MW-1:0];
  assign ram_wdata = clearing ? '0 : acc_reg;

  acpu_ram #(
    .DEPTH(acpu_pkg::MEM_DEPTH),
    .WIDTH(DW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_accept),
    .raddr(in_addr[MW-1:0]),
    .rdata(rdata)
  );

  // issue stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (exe_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // issue stage payload and store forwarding capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op       <= s_axis_tdata[DW-1:acpu_pkg::SEL_W];
      s1_sel      <= s_axis_tdata[acpu_pkg::SEL_W-1:0];
      s1_arg      <= s_axis_tdata[2*DW-1:DW];
      s1_mem_ok   <= in_mem_ok;
      s1_fwd      <= exe_fire && res.mem_we && (s1_addr == in_addr);
      s1_fwd_data <= acc_reg;
    end
  end

  // loaded byte, zero beyond the memory
  assign mem_data = !s1_mem_ok ? '0 : (s1_fwd ? s1_fwd_data : rdata);

  acpu_alu u_alu (
    .op      (s1_op),
    .sel     (s1_sel),
    .arg     (s1_arg),
    .acc     (acc_reg),
    .carry   (carry_reg),
    .reg_data(regs[s1_sel]),
    .mem_data(mem_data),
    .mem_ok  (s1_mem_ok),
    .res     (res)
  );

  // accumulator, carry and register file
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_reg   <= '0;
      carry_reg <= 1'b0;
      for (int i = 0; i < acpu_pkg::NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (exe_fire) begin
      acc_reg   <= res.acc;
      carry_reg <= res.carry;
      if (res.reg_we) begin
        regs[s1_sel] <= acc_reg;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exe_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (exe_fire) begin
      out_acc    <= res.acc;
      out_carry  <= res.carry;
      out_jump   <= res.jump_taken;
      out_target <= res.jump_target;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(acpu_pkg::OUT_TDATA_W - DW - 2 - AW)'(0),
                          out_target, out_jump, out_carry, out_acc};

endmodule

`default_nettype wire

### verif/tb.sv
// tb: self-checking testbench for accumulator_cpu_execute_unit; drives instruction
// requests on s_axis, predicts each result and checks it on m_axis; uses acpu_pkg
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 8;

  localparam int DW = acpu_pkg::DATA_W;
  localparam int AW = acpu_pkg::ADDR_W;
  localparam int SW = acpu_pkg::SEL_W;

  // expected outcome of one instruction
  typedef struct packed {
    logic [DW-1:0] acc;
    logic          carry;
    logic          jump_taken;
    logic [AW-1:0] jump_target;
  } instr_outcome_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [acpu_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [acpu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

  // architectural state mirrored by the predictor
  logic [DW-1:0] acc_q;
  logic          carry_q;
  logic [DW-1:0] regs_q [acpu_pkg::NUM_REGS];
  logic [DW-1:0] mem_q [acpu_pkg::MEM_DEPTH];

  instr_outcome_t pending_results[$];
  int             failures = 0;
  int             instrs_issued = 0;
  int             results_checked = 0;
  int             jumps_seen = 0;
  int             cycle_count = 0;
  logic           steady = 1'b0;

  accumulator_cpu_execute_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver backpressure, none while steady
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 23);
  end

  // execute one instruction against the mirrored state
  function automatic instr_outcome_t execute_instr(logic [7:0] opc_byte, logic [7:0] arg);
    logic [acpu_pkg::OPC_W-1:0] op;
    logic [SW-1:0]              sel;
    logic [AW-1:0]              addr;
    logic [DW:0]                sum;
    logic [DW-1:0]              a;
    logic                       jump;
    instr_outcome_t             res;
    op   = opc_byte[7:3];
    sel  = opc_byte[2:0];
    addr = {sel, arg};
    a    = acc_q;
    jump = 1'b0;
    case (op)
      acpu_pkg::OP_NOT: a = ~a;
      acpu_pkg::OP_LDR: a = regs_q[sel];
      acpu_pkg::OP_STR: regs_q[sel] = a;
      acpu_pkg::OP_LDM: a = (addr < acpu_pkg::MEM_DEPTH) ? mem_q[addr] : '0;
      acpu_pkg::OP_STM: if (addr < acpu_pkg::MEM_DEPTH) mem_q[addr] = a;
      acpu_pkg::OP_LDI: a = arg;
      acpu_pkg::OP_ORR: a = a | regs_q[sel];
      acpu_pkg::OP_AND: a = a & regs_q[sel];
      acpu_pkg::OP_XOR: a = a ^ regs_q[sel];
      acpu_pkg::OP_ADD: begin
        sum     = {1'b0, a} + {1'b0, regs_q[sel]};
        a       = sum[DW-1:0];
        carry_q = sum[DW];
      end
      acpu_pkg::OP_BSL: a = {a[6:0], 1'b0};
      acpu_pkg::OP_BSR: a = {1'b0, a[7:1]};
      acpu_pkg::OP_BRL: a = {a[6:0], a[7]};
      acpu_pkg::OP_BRR: a = {a[0], a[7:1]};
      acpu_pkg::OP_JMP: jump = 1'b1;
      acpu_pkg::OP_JC0: jump = !carry_q;
      acpu_pkg::OP_JC1: jump = carry_q;
      acpu_pkg::OP_JA0: jump = (a == '0);
      acpu_pkg::OP_JA1: jump = (a != '0);
      default: ;
    endcase
    acc_q           = a;
    res.acc         = a;
    res.carry       = carry_q;
    res.jump_taken  = jump;
    res.jump_target = jump ? addr : '0;
    return res;
  endfunction

  // send one instruction request, predict its result once accepted
  task automatic issue_instr(input logic [7:0] opc_byte, input logic [7:0] arg);
    instr_outcome_t res;
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {arg, opc_byte};
    do @(posedge clk); while (!s_axis_tready);
    res = execute_instr(opc_byte, arg);
    pending_results.push_back(res);
    instrs_issued++;
    if (res.jump_taken) jumps_seen++;
  endtask

  // hold off requests until every result has come back
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      failures++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    instr_outcome_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result 0x%0h with nothing pending", m_axis_tdata);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("accumulator", exp_res.acc, m_axis_tdata[7:0]);
        check_field("carry_flag", exp_res.carry, m_axis_tdata[8]);
        check_field("jump_taken", exp_res.jump_taken, m_axis_tdata[9]);
        check_field("jump_target", exp_res.jump_target, m_axis_tdata[20:10]);
        check_field("padding", 0, m_axis_tdata[23:21]);
        results_checked++;
      end
    end
  end

  // every operation, field extremes, unknown opcode, taken and untaken jumps
  task automatic test_directed();
    issue_instr({acpu_pkg::OP_LDI, 3'd7}, 8'hFF);
    issue_instr({acpu_pkg::OP_STR, 3'd7}, 8'h00);
    issue_instr({acpu_pkg::OP_NOT, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_JA0, 3'd7}, 8'hFF);
    issue_instr({acpu_pkg::OP_LDI, 3'd0}, 8'h01);
    issue_instr({acpu_pkg::OP_ADD, 3'd7}, 8'h00);
    issue_instr({acpu_pkg::OP_JC1, 3'd5}, 8'h5A);
    issue_instr({acpu_pkg::OP_JC0, 3'd2}, 8'h00);
    issue_instr({acpu_pkg::OP_JA1, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_LDI, 3'd0}, 8'hA5);
    issue_instr({acpu_pkg::OP_STM, 3'd7}, 8'hFF);
    issue_instr({acpu_pkg::OP_STR, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_LDM, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_LDM, 3'd7}, 8'hFF);
    issue_instr({acpu_pkg::OP_LDR, 3'd7}, 8'h00);
    issue_instr({acpu_pkg::OP_AND, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_XOR, 3'd7}, 8'h00);
    issue_instr({acpu_pkg::OP_ORR, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_BSL, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_BRR, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_BRL, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_BSR, 3'd0}, 8'h00);
    issue_instr({acpu_pkg::OP_JMP, 3'd0}, 8'h00);
    issue_instr(8'hFF, 8'hFF);
    issue_instr({acpu_pkg::OP_NOP, 3'd7}, 8'hFF);
    issue_instr({acpu_pkg::OP_ADD, 3'd2}, 8'h00);
    issue_instr({acpu_pkg::OP_JC0, 3'd3}, 8'h33);
    issue_instr({acpu_pkg::OP_JA1, 3'd1}, 8'h23);
  endtask

  // store followed at once by a load of the same or a neighboring address
  task automatic test_store_forwarding();
    logic [AW-1:0] addr;
    steady = 1'b1;
    repeat (12) begin
      addr = AW'($urandom_range(acpu_pkg::MEM_DEPTH - 1));
      issue_instr({acpu_pkg::OP_LDI, 3'd0}, 8'($urandom));
      issue_instr({acpu_pkg::OP_STM, addr[10:8]}, addr[7:0]);
      issue_instr({acpu_pkg::OP_LDM, addr[10:8]}, addr[7:0]);
      issue_instr({acpu_pkg::OP_NOT, 3'd0}, 8'h00);
      issue_instr({acpu_pkg::OP_STM, addr[10:8]}, addr[7:0]);
      issue_instr({acpu_pkg::OP_LDM, addr[10:8]}, addr[7:0] ^ 8'h01);
      issue_instr({acpu_pkg::OP_LDM, addr[10:8]}, addr[7:0]);
    end
    steady = 1'b0;
  endtask

  function automatic logic [acpu_pkg::OPC_W-1:0] pick_op();
    case ($urandom_range(19))
      0:  return acpu_pkg::OP_NOP;
      1:  return acpu_pkg::OP_NOT;
      2:  return acpu_pkg::OP_LDR;
      3:  return acpu_pkg::OP_STR;
      4:  return acpu_pkg::OP_LDM;
      5:  return acpu_pkg::OP_STM;
      6:  return acpu_pkg::OP_LDI;
      7:  return acpu_pkg::OP_ORR;
      8:  return acpu_pkg::OP_AND;
      9:  return acpu_pkg::OP_XOR;
      10: return acpu_pkg::OP_ADD;
      11: return acpu_pkg::OP_BSL;
      12: return acpu_pkg::OP_BSR;
      13: return acpu_pkg::OP_BRL;
      14: return acpu_pkg::OP_BRR;
      15: return acpu_pkg::OP_JMP;
      16: return acpu_pkg::OP_JC0;
      17: return acpu_pkg::OP_JC1;
      18: return acpu_pkg::OP_JA0;
      default: return acpu_pkg::OP_JA1;
    endcase
  endfunction

  // short programs with random content, mixed with stray instructions
  task automatic test_random_programs(input int count);
    logic [AW-1:0] addr_pool [8];
    logic [AW-1:0] addr;
    logic [SW-1:0] r;
    int            stop_at;
    int            pick;
    stop_at = instrs_issued + count;
    foreach (addr_pool[i]) addr_pool[i] = AW'($urandom_range(acpu_pkg::MEM_DEPTH - 1));
    while (instrs_issued < stop_at) begin
      pick = $urandom_range(99);
      r    = SW'($urandom);
      if (pick < 20) begin
        // memory round trip, often to an address used before
        if ($urandom_range(3) == 0)
          addr_pool[$urandom_range(7)] = AW'($urandom_range(acpu_pkg::MEM_DEPTH - 1));
        addr = addr_pool[$urandom_range(7)];
        issue_instr({acpu_pkg::OP_LDI, r}, 8'($urandom));
        issue_instr({acpu_pkg::OP_STM, addr[10:8]}, addr[7:0]);
        repeat ($urandom_range(2)) issue_instr({pick_op(), 3'($urandom)}, 8'($urandom));
        addr = addr_pool[$urandom_range(7)];
        issue_instr({acpu_pkg::OP_LDM, addr[10:8]}, addr[7:0]);
      end else if (pick < 35) begin
        // add that may carry, then a carry jump
        issue_instr({acpu_pkg::OP_LDI, 3'($urandom)}, 8'($urandom));
        issue_instr({acpu_pkg::OP_STR, r}, 8'($urandom));
        issue_instr({acpu_pkg::OP_LDI, 3'($urandom)}, 8'($urandom));
        issue_instr({acpu_pkg::OP_ADD, r}, 8'($urandom));
        issue_instr({($urandom_range(1) != 0) ? acpu_pkg::OP_JC1 : acpu_pkg::OP_JC0,
                     3'($urandom)},
                    8'($urandom));
      end else if (pick < 50) begin
        // register round trip through a logic operation
        issue_instr({acpu_pkg::OP_LDI, 3'($urandom)}, 8'($urandom));
        issue_instr({acpu_pkg::OP_STR, r}, 8'($urandom));
        issue_instr({acpu_pkg::OP_LDI, 3'($urandom)}, 8'($urandom));
        case ($urandom_range(2))
          0: issue_instr({acpu_pkg::OP_ORR, r}, 8'($urandom));
          1: issue_instr({acpu_pkg::OP_AND, r}, 8'($urandom));
          default: issue_instr({acpu_pkg::OP_XOR, r}, 8'($urandom));
        endcase
        issue_instr({acpu_pkg::OP_LDR, r}, 8'($urandom));
      end else if (pick < 60) begin
        // shifts and rotations, then a zero test jump
        issue_instr({acpu_pkg::OP_LDI, r}, ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(3))
            0: issue_instr({acpu_pkg::OP_BSL, 3'($urandom)}, 8'($urandom));
            1: issue_instr({acpu_pkg::OP_BSR, 3'($urandom)}, 8'($urandom));
            2: issue_instr({acpu_pkg::OP_BRL, 3'($urandom)}, 8'($urandom));
            default: issue_instr({acpu_pkg::OP_BRR, 3'($urandom)}, 8'($urandom));
          endcase
        end
        issue_instr({($urandom_range(1) != 0) ? acpu_pkg::OP_JA1 : acpu_pkg::OP_JA0,
                     3'($urandom)},
                    8'($urandom));
      end else if (pick < 88) begin
        issue_instr({pick_op(), r}, 8'($urandom));
      end else begin
        // any opcode byte, unknown ones included
        issue_instr(8'($urandom), 8'($urandom));
      end
    end
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    steady = 1'b1;
    test_random_programs(300);
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    acc_q   = '0;
    carry_q = 1'b0;
    foreach (regs_q[i]) regs_q[i] = '0;
    foreach (mem_q[i]) mem_q[i] = '0;

    test_directed();
    wait_for_results();
    test_store_forwarding();
    test_random_programs(700);
    wait_for_results();
    test_back_to_back();
    test_random_programs(700);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered every operation, unknown opcodes, store-to-load forwarding and");
    $display("%0d instructions with %0d results checked, %0d jumps taken",
             instrs_issued, results_checked, jumps_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/acpu_pkg.sv
src/acpu_ram.sv
src/acpu_alu.sv
src/accumulator_cpu_execute_unit.sv
verif/tb.sv
